### design/ddpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpi_pkg
// Shared types, constants and the arctangent table of the pose integrator.
// ----------------------------------------------------------------------------
package ddpi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;

  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int ANGLE_DROP   = 32 - ANGLE_BITS;
  localparam logic [31:0] ANGLE_KEEP = 32'hFFFF_FFFF << ANGLE_DROP;

  // CORDIC datapath word: Q2.30 plus guard bits
  localparam int CW = 34;
  // serial multiplier: multiplier bits per product, accumulator width
  localparam int MUL_STEPS = 24;
  localparam int MUL_ACC_W = CW + 1;
  // cos/sin are Q2.30; the accumulator already holds product / 2^MUL_STEPS
  localparam int POS_SHIFT = 30 - MUL_STEPS;

  localparam logic signed [31:0] CORDIC_GAIN     = 32'sd652032875;
  localparam logic [15:0]        TIME_STEP_RESET = 16'd2621;

  typedef enum logic [1:0] {
    CMD_SET_VEL   = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_LOAD_POSE = 2'd2
  } ddpi_cmd_e;

  typedef enum logic [1:0] {
    REG_TIME_STEP     = 2'd0,
    REG_START_X       = 2'd1,
    REG_START_Y       = 2'd2,
    REG_START_HEADING = 2'd3
  } ddpi_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } ddpi_state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] linear_speed;
    logic signed [23:0] turn_rate;
  } ddpi_cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } ddpi_pose_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // table entry rounded to the angle resolution, in 2^-32 turn
  function automatic logic signed [CW-1:0] atan_step(input logic [4:0] idx);
    logic [32:0] r;
    r = '0;
    if (int'(idx) < ATAN_LEN) begin
      r = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (ANGLE_DROP - 1));
      r = (r >> ANGLE_DROP) << ANGLE_DROP;
    end
    return {{(CW-33){1'b0}}, r};
  endfunction

endpackage

### design/ddpi_smul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpi_smul
// Bit-serial signed multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module ddpi_smul
  import ddpi_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [CW-1:0]        mcand,
  input  logic signed [MUL_STEPS-1:0] mplier,
  output logic                        busy,
  output logic                        done,
  output logic signed [MUL_ACC_W-1:0] hi,
  output logic [MUL_STEPS-1:0]        lo
);

  logic                        active;
  logic [4:0]                  count;
  logic [MUL_STEPS-1:0]        mreg;
  logic signed [CW-1:0]        mcand_r;
  logic signed [MUL_ACC_W-1:0] acc;
  logic [MUL_STEPS-1:0]        lo_r;
  logic                        done_r;

  logic                        last;
  logic signed [MUL_ACC_W:0]   addend;
  logic signed [MUL_ACC_W:0]   sum;

  always_comb begin
    last   = (count == 5'(MUL_STEPS - 1));
    addend = mreg[0] ? {{2{mcand_r[CW-1]}}, mcand_r} : '0;
    // MSB of a two's complement multiplier carries negative weight
    sum    = last ? ({acc[MUL_ACC_W-1], acc} - addend)
                  : ({acc[MUL_ACC_W-1], acc} + addend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_r <= 1'b0;
      count  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active  <= 1'b1;
        count   <= '0;
        mreg    <= mplier;
        mcand_r <= mcand;
        acc     <= '0;
      end else if (active) begin
        acc   <= sum[MUL_ACC_W:1];
        lo_r  <= {sum[0], lo_r[MUL_STEPS-1:1]};
        mreg  <= {1'b0, mreg[MUL_STEPS-1:1]};
        count <= count + 5'd1;
        if (last) begin
          active <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = active;
  assign done = done_r;
  assign hi   = acc;
  assign lo   = lo_r;

  a_done_after_step: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(active))
    else $error("multiplier done without a running product");

endmodule

### design/ddpi_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpi_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, cos/sin in Q2.30.
// ----------------------------------------------------------------------------
module ddpi_cordic
  import ddpi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [15:0]          angle,
  output logic                 busy,
  output logic                 done,
  output logic signed [CW-1:0] cos_val,
  output logic signed [CW-1:0] sin_val
);

  logic                 active;
  logic                 done_r;
  logic [4:0]           iter;
  logic                 flip;
  logic signed [CW-1:0] xr;
  logic signed [CW-1:0] yr;
  logic signed [CW-1:0] zr;

  logic [31:0]          a_in;
  logic [31:0]          a_off;
  logic                 flip_in;
  logic [31:0]          a_red;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] step;
  logic                 last;

  always_comb begin
    a_in    = {angle, 16'h0000} & ANGLE_KEEP;
    a_off   = a_in + 32'h4000_0000;
    flip_in = a_off[31];
    a_red   = flip_in ? (a_in + 32'h8000_0000) : a_in;
    xs      = xr >>> iter;
    ys      = yr >>> iter;
    step    = atan_step(iter);
    last    = (iter == 5'(CORDIC_ITERS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_r <= 1'b0;
      iter   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active <= 1'b1;
        iter   <= '0;
        flip   <= flip_in;
        xr     <= {{(CW-32){1'b0}}, CORDIC_GAIN};
        yr     <= '0;
        zr     <= {{(CW-32){a_red[31]}}, a_red};
      end else if (active) begin
        if (!zr[CW-1]) begin
          xr <= xr - ys;
          yr <= yr + xs;
          zr <= zr - step;
        end else begin
          xr <= xr + ys;
          yr <= yr - xs;
          zr <= zr + step;
        end
        iter <= iter + 5'd1;
        if (last) begin
          active <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy    = active;
  assign done    = done_r;
  assign cos_val = flip ? -xr : xr;
  assign sin_val = flip ? -yr : yr;

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("cordic done flag out of step with its run");

endmodule

### design/diff_drive_pose_integrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_pose_integrator_unit
// Unicycle odometry: Euler step of x, y and heading on each tick command.
//
//   port group   role     transaction when
//   cmd          in       cmd_valid && !cmd_stall
//   pose         out      pose_valid && !pose_stall
//   cfg_*        write    cfg_we
//
// Set velocity and reload pose are applied on acceptance and give no pose.
// A tick runs from its transaction through speed*dt and rate*dt (CORDIC
// runs alongside), then cos*d and sin*d ending with the x/y update, then
// the load of the pose register and the return to idle.
// The output register frees the core once loaded; a stalled pose holds
// only the final load step. Synchronous reset clears the current pose,
// pose_valid, speeds and start registers; time step returns to 2621.
// ----------------------------------------------------------------------------
module diff_drive_pose_integrator_unit
  import ddpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  ddpi_cmd_t   cmd,
  output logic        pose_valid,
  input  logic        pose_stall,
  output ddpi_pose_t  pose,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ddpi_state_e state, state_next;

  logic [15:0]        time_step;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic [15:0]        start_heading;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic [15:0]        cur_heading;
  logic signed [23:0] held_speed;
  logic signed [23:0] held_rate;

  logic                        accept;
  logic                        start_phase1;
  logic                        start_phase2;
  logic                        load_pose;
  logic                        mul_start;
  logic signed [CW-1:0]        mx_cand;
  logic signed [CW-1:0]        my_cand;
  logic signed [MUL_STEPS-1:0] mx_plier;
  logic signed [MUL_STEPS-1:0] my_plier;
  logic                        mx_busy, my_busy, mx_done, my_done;
  logic signed [MUL_ACC_W-1:0] mx_hi, my_hi;
  logic [MUL_STEPS-1:0]        mx_lo, my_lo;
  logic                        cordic_busy, cordic_done;
  logic signed [CW-1:0]        cos_val, sin_val;

  logic signed [23:0]          travel;
  logic [15:0]                 dhead;
  logic signed [MUL_ACC_W-1:0] rx, ry;
  logic signed [MUL_ACC_W-1:0] dx, dy;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                 input logic signed [MUL_ACC_W-1:0] delta);
    logic signed [MUL_ACC_W:0] s;
    s = {{(MUL_ACC_W-31){base[31]}}, base} + {delta[MUL_ACC_W-1], delta};
    if (s > (MUL_ACC_W+1)'(64'sd2147483647)) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -(MUL_ACC_W+1)'(64'sd2147483648)) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.command == CMD_TICK) begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (mx_done) begin
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mx_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!pose_valid || !pose_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_stall    = (state != ST_IDLE);
    accept       = cmd_valid && (state == ST_IDLE);
    start_phase1 = accept && (cmd.command == CMD_TICK);
    start_phase2 = (state == ST_MUL1) && mx_done;
    load_pose    = (state == ST_OUT) && (!pose_valid || !pose_stall);
    mul_start    = start_phase1 || start_phase2;
  end

  // datapath around the multipliers
  always_comb begin
    travel = {mx_hi[15:0], mx_lo[MUL_STEPS-1:16]} + 24'(mx_lo[15]);
    dhead  = {my_hi[7:0], my_lo[MUL_STEPS-1:16]} + 16'(my_lo[15]);
    if (state == ST_IDLE) begin
      mx_cand  = {{(CW-24){held_speed[23]}}, held_speed};
      my_cand  = {{(CW-24){held_rate[23]}}, held_rate};
      mx_plier = {{(MUL_STEPS-16){1'b0}}, time_step};
      my_plier = {{(MUL_STEPS-16){1'b0}}, time_step};
    end else begin
      mx_cand  = cos_val;
      my_cand  = sin_val;
      mx_plier = travel;
      my_plier = travel;
    end
    rx = mx_hi + MUL_ACC_W'(1 << (POS_SHIFT - 1));
    ry = my_hi + MUL_ACC_W'(1 << (POS_SHIFT - 1));
    dx = rx >>> POS_SHIFT;
    dy = ry >>> POS_SHIFT;
  end

  ddpi_smul u_mul_x (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mx_cand),
    .mplier (mx_plier),
    .busy   (mx_busy),
    .done   (mx_done),
    .hi     (mx_hi),
    .lo     (mx_lo)
  );

  ddpi_smul u_mul_y (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (my_cand),
    .mplier (my_plier),
    .busy   (my_busy),
    .done   (my_done),
    .hi     (my_hi),
    .lo     (my_lo)
  );

  ddpi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (start_phase1),
    .angle   (cur_heading),
    .busy    (cordic_busy),
    .done    (cordic_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      time_step     <= TIME_STEP_RESET;
      start_x       <= '0;
      start_y       <= '0;
      start_heading <= '0;
      cur_x         <= '0;
      cur_y         <= '0;
      cur_heading   <= '0;
      held_speed    <= '0;
      held_rate     <= '0;
      pose_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP:     time_step     <= cfg_data[15:0];
          REG_START_X:       start_x       <= cfg_data;
          REG_START_Y:       start_y       <= cfg_data;
          REG_START_HEADING: start_heading <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (accept) begin
        case (cmd.command)
          CMD_SET_VEL: begin
            held_speed <= cmd.linear_speed;
            held_rate  <= cmd.turn_rate;
          end
          CMD_LOAD_POSE: begin
            cur_x       <= start_x;
            cur_y       <= start_y;
            cur_heading <= start_heading;
          end
          default: ;
        endcase
      end

      if (start_phase2) begin
        cur_heading <= cur_heading + dhead;
      end

      if ((state == ST_MUL2) && mx_done) begin
        cur_x <= sat_add(cur_x, dx);
        cur_y <= sat_add(cur_y, dy);
      end

      if (load_pose) begin
        pose_valid <= 1'b1;
      end else if (!pose_stall) begin
        pose_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pose) begin
      pose.pos_x   <= cur_x;
      pose.pos_y   <= cur_y;
      pose.heading <= cur_heading;
    end
  end

  a_pose_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> $past(state) == ST_OUT)
    else $error("pose raised outside the output step");

  a_cordic_before_mul2: assert property (@(posedge clk) disable iff (rst)
    start_phase2 |-> !cordic_busy)
    else $error("cos/sin used before the rotation finished");

  a_cordic_done_in_mul1: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> state == ST_MUL1)
    else $error("rotation finished outside the first multiply step");

  a_muls_in_lockstep: assert property (@(posedge clk) disable iff (rst)
    (mx_busy == my_busy) && (mx_done == my_done))
    else $error("x and y multipliers out of step");

endmodule

### tb/sv/diff_drive_pose_integrator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_pose_integrator_unit_test
// Self-checking bench for the differential-drive pose integrator.
//
// Commands are queued by the main sequence and issued by a clocked driver
// with random gaps. An in-bench odometry model (CORDIC, rounding, clamping)
// predicts every pose, and a clocked monitor compares each pose transaction
// with the oldest prediction. The pose side stalls at random and holds off
// for long stretches so the block backs up into its command input.
// ----------------------------------------------------------------------------
module diff_drive_pose_integrator_unit_test
  import ddpi_pkg::*;
();

  localparam logic [1:0]         CMD_UNUSED = 2'd3;
  localparam logic signed [23:0] FIELD_MAX  = 24'sh7FFFFF;
  localparam logic signed [23:0] FIELD_MIN  = 24'sh800000;
  localparam int                 IDLE_PCT   = 22;
  localparam int                 DRAIN_WAIT = 80;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cmd_valid  = 1'b0;
  logic        cmd_stall;
  ddpi_cmd_t   cmd        = '0;
  logic        pose_valid;
  logic        pose_stall = 1'b0;
  ddpi_pose_t  pose;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;

  // odometry model state and register copies
  logic [31:0]        track_x;
  logic [31:0]        track_y;
  logic [15:0]        track_heading;
  logic signed [23:0] track_speed;
  logic signed [23:0] track_rate;
  logic [15:0]        step_reg;
  logic [31:0]        home_x;
  logic [31:0]        home_y;
  logic [15:0]        home_heading;

  ddpi_cmd_t  cmd_backlog[$];
  ddpi_pose_t pose_expected[$];
  ddpi_pose_t head_pose;
  logic       cmd_taken = 1'b0;
  logic       calm      = 1'b0;
  int         hold_clock = 0;
  int         mismatches = 0;

  diff_drive_pose_integrator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pose_valid(pose_valid),
    .pose_stall(pose_stall),
    .pose      (pose),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("pose check: %s", msg);
    mismatches++;
  endtask

  function automatic void heading_to_cos_sin(input logic [15:0] hdg, output longint cos_q30,
                                             output longint sin_q30);
    logic [31:0] ang;
    logic [31:0] probe;
    logic        flip;
    longint      z;
    longint      xa;
    longint      ya;
    longint      xn;
    longint      step;
    int          i;
    ang   = {hdg, 16'h0000} & ANGLE_KEEP;
    probe = ang + 32'h4000_0000;
    flip  = probe[31];
    if (flip) ang = ang + 32'h8000_0000;
    z  = longint'($signed(ang));
    xa = longint'(CORDIC_GAIN);
    ya = 0;
    for (i = 0; i < CORDIC_ITERS; i++) begin
      step = ((longint'(ATAN_TURN32[i]) + (longint'(1) <<< (ANGLE_DROP - 1))) >>> ANGLE_DROP)
             <<< ANGLE_DROP;
      if (z >= 0) begin
        xn = xa - (ya >>> i);
        ya = ya + (xa >>> i);
        z  = z - step;
      end else begin
        xn = xa + (ya >>> i);
        ya = ya - (xa >>> i);
        z  = z + step;
      end
      xa = xn;
    end
    cos_q30 = flip ? -xa : xa;
    sin_q30 = flip ? -ya : ya;
  endfunction

  function automatic logic [31:0] clamp_add(input logic [31:0] base, input longint delta);
    longint r;
    r = longint'($signed(base)) + delta;
    if (r > longint'(32'sh7FFF_FFFF)) r = longint'(32'sh7FFF_FFFF);
    if (r < longint'(32'sh8000_0000)) r = longint'(32'sh8000_0000);
    return r[31:0];
  endfunction

  task automatic advance_odometry(input ddpi_cmd_t c);
    longint     dt;
    longint     travel;
    longint     dturn;
    longint     cs;
    longint     sn;
    ddpi_pose_t p;
    case (c.command)
      CMD_SET_VEL: begin
        track_speed = c.linear_speed;
        track_rate  = c.turn_rate;
      end
      CMD_LOAD_POSE: begin
        track_x       = home_x;
        track_y       = home_y;
        track_heading = home_heading;
      end
      CMD_TICK: begin
        dt     = longint'(step_reg);
        travel = (longint'(track_speed) * dt + 32768) >>> 16;
        dturn  = (longint'(track_rate) * dt + 32768) >>> 16;
        heading_to_cos_sin(track_heading, cs, sn);
        track_x       = clamp_add(track_x, (cs * travel + (longint'(1) <<< 29)) >>> 30);
        track_y       = clamp_add(track_y, (sn * travel + (longint'(1) <<< 29)) >>> 30);
        track_heading = track_heading + dturn[15:0];
        p.pos_x   = track_x;
        p.pos_y   = track_y;
        p.heading = track_heading;
        pose_expected.push_back(p);
      end
      default: ;
    endcase
  endtask

  function automatic ddpi_cmd_t cmd_item(input logic [1:0] op, input logic [23:0] spd,
                                         input logic [23:0] rt);
    ddpi_cmd_t c;
    c.command      = op;
    c.linear_speed = spd;
    c.turn_rate    = rt;
    return c;
  endfunction

  function automatic logic [23:0] random_motion();
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom);
      1: v = $urandom_range(1) ? int'(FIELD_MAX) : int'(FIELD_MIN);
      default: v = int'($urandom_range(393216)) - 196608;
    endcase
    return v[23:0];
  endfunction

  function automatic ddpi_cmd_t random_cmd();
    ddpi_cmd_t c;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 24)      c.command = CMD_SET_VEL;
    else if (pick < 80) c.command = CMD_TICK;
    else if (pick < 95) c.command = CMD_LOAD_POSE;
    else                c.command = CMD_UNUSED;
    c.linear_speed = random_motion();
    c.turn_rate    = random_motion();
    return c;
  endfunction

  function automatic logic [31:0] random_coord();
    int v;
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: begin
        v = int'($urandom_range(1 << 24)) - (1 << 23);
        return v;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_heading();
    case ($urandom_range(9))
      0: return 16'h3FFF;
      1: return 16'h4000;
      2: return 16'h8000;
      3: return 16'hBFFF;
      4: return 16'hC000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_time_step();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return TIME_STEP_RESET;
      3: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input ddpi_reg_e idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TIME_STEP:     step_reg     = val[15:0];
      REG_START_X:       home_x       = val;
      REG_START_Y:       home_y       = val;
      REG_START_HEADING: home_heading = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (cmd_backlog.size() != 0 || cmd_valid || pose_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd_valid && !cmd_taken) begin
      // hold the stalled transaction
    end else if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
      cmd       <= cmd_backlog.pop_front();
      cmd_valid <= 1'b1;
    end else begin
      cmd_valid <= 1'b0;
    end
  end

  // pose receiver: random stalls plus a periodic long hold-off
  always @(negedge clk) begin
    hold_clock = hold_clock + 1;
    if (hold_clock % 5000 >= 4600) begin
      pose_stall <= 1'b1;
    end else begin
      pose_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor: pose check, then command acceptance and prediction
  always @(posedge clk) begin
    if (!rst && pose_valid && !pose_stall) begin
      if (pose_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected pose x=%0d y=%0d h=%0d",
                                  pose.pos_x, pose.pos_y, pose.heading));
      end else begin
        head_pose = pose_expected.pop_front();
        if (pose.pos_x !== head_pose.pos_x || pose.pos_y !== head_pose.pos_y ||
            pose.heading !== head_pose.heading) begin
          report_mismatch($sformatf("got x=%0d y=%0d h=%0d, predicted x=%0d y=%0d h=%0d",
                                    pose.pos_x, pose.pos_y, pose.heading,
                                    head_pose.pos_x, head_pose.pos_y, head_pose.heading));
        end
      end
    end
    cmd_taken <= !rst && cmd_valid && !cmd_stall;
    if (!rst && cmd_valid && !cmd_stall) advance_odometry(cmd);
  end

  initial begin
    #10_000_000;
    $display("diff_drive_pose_integrator_unit: mismatch");
    $finish;
  end

  initial begin
    int phase;
    int n;
    track_x       = '0;
    track_y       = '0;
    track_heading = '0;
    track_speed   = '0;
    track_rate    = '0;
    step_reg      = TIME_STEP_RESET;
    home_x        = '0;
    home_y        = '0;
    home_heading  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero motion, extremes of speed and rate, unused code, reload
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_SET_VEL, FIELD_MAX, FIELD_MAX));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_SET_VEL, FIELD_MIN, FIELD_MIN));
    cmd_backlog.push_back(cmd_item(CMD_TICK, FIELD_MAX, FIELD_MAX));
    cmd_backlog.push_back(cmd_item(CMD_UNUSED, FIELD_MAX, FIELD_MIN));
    cmd_backlog.push_back(cmd_item(CMD_LOAD_POSE, FIELD_MIN, FIELD_MAX));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_SET_VEL, 24'sh018000, 24'sh001000));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    settle();

    // x clamps at its upper limit, heading zero, largest time step
    write_reg(REG_TIME_STEP, 32'h0000_FFFF);
    write_reg(REG_START_X, 32'h7FFF_0000);
    write_reg(REG_START_Y, 32'h8001_0000);
    write_reg(REG_START_HEADING, 32'h0000_0000);
    cmd_backlog.push_back(cmd_item(CMD_LOAD_POSE, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_SET_VEL, FIELD_MAX, '0));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_LOAD_POSE, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_SET_VEL, FIELD_MIN, '0));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    settle();

    // y clamps at its lower limit, quarter turn
    write_reg(REG_START_HEADING, 32'h0000_4000);
    cmd_backlog.push_back(cmd_item(CMD_LOAD_POSE, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_SET_VEL, FIELD_MIN, '0));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    settle();

    // zero time step, half turn, extreme start position
    write_reg(REG_TIME_STEP, 32'h0000_0000);
    write_reg(REG_START_X, 32'h8000_0000);
    write_reg(REG_START_Y, 32'h7FFF_FFFF);
    write_reg(REG_START_HEADING, 32'h0000_8000);
    cmd_backlog.push_back(cmd_item(CMD_LOAD_POSE, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    cmd_backlog.push_back(cmd_item(CMD_SET_VEL, FIELD_MAX, FIELD_MAX));
    cmd_backlog.push_back(cmd_item(CMD_TICK, '0, '0));
    settle();

    for (phase = 0; phase < 6; phase++) begin
      @(posedge clk);
      calm = (phase == 2);
      write_reg(REG_TIME_STEP, {16'h0000, random_time_step()});
      write_reg(REG_START_X, random_coord());
      write_reg(REG_START_Y, random_coord());
      write_reg(REG_START_HEADING, {16'h0000, random_heading()});
      cmd_backlog.push_back(cmd_item(CMD_LOAD_POSE, '0, '0));
      for (n = 0; n < 75; n++) cmd_backlog.push_back(random_cmd());
      settle();
    end

    if (mismatches == 0) begin
      $display("diff_drive_pose_integrator_unit: match");
    end else begin
      $display("diff_drive_pose_integrator_unit: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
design/ddpi_pkg.sv
design/ddpi_smul.sv
design/ddpi_cordic.sv
design/diff_drive_pose_integrator_unit.sv
tb/sv/diff_drive_pose_integrator_unit_test.sv
